/* sv/priority_ready_queue_scheduler_macros.svh */
// Assertion macros for the priority ready queue scheduler.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH

// Plain clocked assertion, disabled during reset.
`define PRQS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Assertion that only applies in cycles where cond holds.
`define PRQS_ASSERT_WHEN(lbl, clk, rstn, cond, prop, msg) \
  `PRQS_ASSERT(lbl, clk, rstn, (cond) |-> (prop), msg)

`endif

/* sv/prqs_pkg.sv */
// Shared types and constants of the priority ready queue scheduler.
`default_nettype none
package prqs_pkg;

  localparam int unsigned PRIO_IN_W  = 8;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic {
    ACT_ACTIVATE  = 1'b0,
    ACT_TERMINATE = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NOFREE = 2'd1,
    STATUS_IDLE   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_UNLINK,
    CMD_PLACE,
    CMD_WALK,
    CMD_INS_W1,
    CMD_INS_W2,
    CMD_FIN
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNLINK,
    ST_PLACE,
    ST_WALK,
    ST_INS_W1,
    ST_INS_W2,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load_err;
    logic op_term;
    logic place_self;
    logic lower;
    logic wrap;
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

/* sv/prqs_if.sv */
// Request and response channel interfaces of the scheduler.
`default_nettype none
interface prqs_req_if;
  import prqs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [PRIO_IN_W-1:0] priority_req;
  modport source (output valid, action, priority_req, input ready);
  modport sink   (input valid, action, priority_req, output ready);
endinterface

interface prqs_rsp_if;
  import prqs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SLOT_OUT_W-1:0] new_slot;
  logic [SLOT_OUT_W-1:0] running_slot;
  logic                  running_valid;
  logic [STATUS_W-1:0]   status;
  modport source (output valid, new_slot, running_slot, running_valid, status, input ready);
  modport sink   (input valid, new_slot, running_slot, running_valid, status, output ready);
endinterface
`default_nettype wire

/* sv/priority_ready_queue_scheduler.sv */
// Non-preemptive priority scheduler over NUM_SLOTS task slots: activate inserts a
// task into a priority-ordered ready ring, terminate retires the running task. One
// request is handled at a time. Activate walks the ready ring, visiting at most
// NUM_SLOTS - 1 entries one per cycle through the priority memory read port, and
// skips the walk when the ready ring is empty; terminate and a rejected request
// do not walk. The result beat is loaded only once the previous beat has been
// taken, and the next request is taken the cycle after it is loaded. No clearing
// pass after reset.
`default_nettype none
module priority_ready_queue_scheduler #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned PRIO_BITS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  prqs_req_if.sink   req_i,
  prqs_rsp_if.source rsp_o
);
  import prqs_pkg::*;

  cmd_e    cmd;
  dp_sts_t sts;

  prqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prqs_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (req_i.action),
    .prio_i          (req_i.priority_req),
    .sts_o           (sts),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .new_slot_o      (rsp_o.new_slot),
    .running_slot_o  (rsp_o.running_slot),
    .running_valid_o (rsp_o.running_valid),
    .status_o        (rsp_o.status)
  );

endmodule
`default_nettype wire

/* sv/prqs_ctrl.sv */
// Sequencer of the scheduler: steps the datapath through one request.
`default_nettype none
module prqs_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire prqs_pkg::dp_sts_t sts_i,
  output prqs_pkg::cmd_e        cmd_o
);
  import prqs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = sts_i.load_err ? ST_FIN : ST_UNLINK;
        end
      end
      ST_UNLINK: begin
        cmd_o   = CMD_UNLINK;
        state_d = ST_PLACE;
      end
      ST_PLACE: begin
        cmd_o = CMD_PLACE;
        if (sts_i.place_self) begin
          state_d = ST_FIN;
        end else if (sts_i.op_term) begin
          state_d = ST_INS_W1;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o = CMD_WALK;
        if (sts_i.lower || sts_i.wrap) begin
          state_d = ST_INS_W1;
        end
      end
      ST_INS_W1: begin
        cmd_o   = CMD_INS_W1;
        state_d = ST_INS_W2;
      end
      ST_INS_W2: begin
        cmd_o   = CMD_INS_W2;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o   = CMD_FIN;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/prqs_dp.sv */
// Datapath of the scheduler: link and priority memories, list heads, result register.
`default_nettype none
module prqs_dp #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned PRIO_BITS = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire prqs_pkg::cmd_e                  cmd_i,
  input  wire logic                            action_i,
  input  wire logic [prqs_pkg::PRIO_IN_W-1:0]  prio_i,
  output prqs_pkg::dp_sts_t                    sts_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [prqs_pkg::SLOT_OUT_W-1:0]      new_slot_o,
  output logic [prqs_pkg::SLOT_OUT_W-1:0]      running_slot_o,
  output logic                                 running_valid_o,
  output logic [prqs_pkg::STATUS_W-1:0]        status_o
);
  import prqs_pkg::*;

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam logic [SW-1:0] LAST = SW'(NUM_SLOTS - 1);

  typedef logic [SW-1:0]        slot_t;
  typedef logic [PRIO_BITS-1:0] prio_t;

  function automatic slot_t ring_succ(slot_t a);
    return (a == LAST) ? '0 : slot_t'(a + 1'b1);
  endfunction

  function automatic slot_t ring_pred(slot_t a);
    return (a == '0) ? LAST : slot_t'(a - 1'b1);
  endfunction

  // Memories
  slot_t nxt_mem [NUM_SLOTS];
  slot_t prv_mem [NUM_SLOTS];
  prio_t pri_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] nxt_vld_q, prv_vld_q;
  slot_t nxt_rd_q, prv_rd_q;
  prio_t pri_rd_q;

  // Scheduler state
  logic  op_q, err_q, lower_q;
  prio_t pr_q;
  slot_t s_q, cur_q, at_q, p_q;
  slot_t rdy_head_q, free_head_q, task_q;
  logic  rdy_ne_q, free_ne_q, task_vld_q;

  // Result register
  logic  out_vld_q;
  logic [SLOT_OUT_W-1:0] new_slot_q, run_slot_q;
  logic  run_vld_q;
  status_e status_q;

  slot_t n_ra, p_ra, pr_ra, n_wa, n_wd, p_wa, p_wd, ld_slot;
  logic  n_we, p_we;
  slot_t task_d;
  logic  task_vld_d;
  status_e status_d;

  assign ld_slot = (action_i == ACT_TERMINATE) ? task_q : free_head_q;

  always_comb begin
    sts_o.load_err   = (action_i == ACT_TERMINATE) ? !task_vld_q : !free_ne_q;
    sts_o.op_term    = op_q;
    sts_o.place_self = op_q ? !free_ne_q : !rdy_ne_q;
    sts_o.lower      = pri_rd_q < pr_q;
    sts_o.wrap       = nxt_rd_q == rdy_head_q;
    sts_o.out_busy   = out_vld_q && !out_ready_i;
  end

  always_comb begin
    n_ra  = s_q;
    p_ra  = s_q;
    pr_ra = cur_q;
    n_we  = 1'b0;
    p_we  = 1'b0;
    n_wa  = s_q;
    n_wd  = s_q;
    p_wa  = s_q;
    p_wd  = s_q;
    case (cmd_i)
      CMD_LOAD: begin
        n_ra = ld_slot;
        p_ra = ld_slot;
      end
      CMD_UNLINK: begin
        if (nxt_rd_q != s_q) begin
          n_we = 1'b1;
          n_wa = prv_rd_q;
          n_wd = nxt_rd_q;
          p_we = 1'b1;
          p_wa = nxt_rd_q;
          p_wd = prv_rd_q;
        end
      end
      CMD_PLACE: begin
        if (sts_o.place_self) begin
          n_we = 1'b1;
          p_we = 1'b1;
        end else if (op_q) begin
          p_ra = free_head_q;
        end else begin
          n_ra  = rdy_head_q;
          pr_ra = rdy_head_q;
        end
      end
      CMD_WALK: begin
        if (sts_o.lower) begin
          p_ra = cur_q;
        end else if (sts_o.wrap) begin
          p_ra = rdy_head_q;
        end else begin
          n_ra  = nxt_rd_q;
          pr_ra = nxt_rd_q;
        end
      end
      CMD_INS_W1: begin
        n_we = 1'b1;
        n_wd = at_q;
        p_we = 1'b1;
        p_wd = prv_rd_q;
      end
      CMD_INS_W2: begin
        n_we = 1'b1;
        n_wa = p_q;
        p_we = 1'b1;
        p_wa = at_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      nxt_mem[n_wa] <= n_wd;
    end
    if (p_we) begin
      prv_mem[p_wa] <= p_wd;
    end
    if (cmd_i == CMD_UNLINK && !op_q) begin
      pri_mem[s_q] <= pr_q;
    end
    nxt_rd_q <= nxt_vld_q[n_ra] ? nxt_mem[n_ra] : ring_succ(n_ra);
    prv_rd_q <= prv_vld_q[p_ra] ? prv_mem[p_ra] : ring_pred(p_ra);
    pri_rd_q <= pri_mem[pr_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_vld_q <= '0;
      prv_vld_q <= '0;
    end else begin
      if (n_we) begin
        nxt_vld_q[n_wa] <= 1'b1;
      end
      if (p_we) begin
        prv_vld_q[p_wa] <= 1'b1;
      end
    end
  end

  always_comb begin
    task_d     = task_q;
    task_vld_d = task_vld_q;
    status_d   = STATUS_OK;
    if (!op_q) begin
      if (err_q) begin
        status_d = STATUS_NOFREE;
      end else if (!task_vld_q) begin
        task_d     = rdy_head_q;
        task_vld_d = 1'b1;
      end
    end else begin
      if (!err_q) begin
        task_d     = rdy_ne_q ? rdy_head_q : '0;
        task_vld_d = rdy_ne_q;
      end
      if (!task_vld_d) begin
        status_d = STATUS_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q  <= action_i;
        pr_q  <= PRIO_BITS'(prio_i);
        s_q   <= ld_slot;
        err_q <= sts_o.load_err;
      end
      CMD_PLACE: begin
        at_q    <= free_head_q;
        lower_q <= 1'b0;
        cur_q   <= rdy_head_q;
      end
      CMD_WALK: begin
        if (sts_o.lower) begin
          at_q    <= cur_q;
          lower_q <= 1'b1;
        end else if (sts_o.wrap) begin
          at_q    <= rdy_head_q;
          lower_q <= 1'b0;
        end else begin
          cur_q <= nxt_rd_q;
        end
      end
      CMD_INS_W1: begin
        p_q <= prv_rd_q;
      end
      CMD_FIN: begin
        new_slot_q <= (!op_q && !err_q) ? SLOT_OUT_W'(s_q) : '0;
        run_slot_q <= task_vld_d ? SLOT_OUT_W'(task_d) : '0;
        run_vld_q  <= task_vld_d;
        status_q   <= status_d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_head_q  <= '0;
      rdy_ne_q    <= 1'b0;
      free_head_q <= '0;
      free_ne_q   <= 1'b1;
      task_q      <= '0;
      task_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (cmd_i)
        CMD_UNLINK: begin
          if (!op_q) begin
            if (nxt_rd_q == s_q) begin
              free_ne_q   <= 1'b0;
              free_head_q <= '0;
            end else begin
              free_head_q <= nxt_rd_q;
            end
          end else begin
            if (nxt_rd_q == s_q) begin
              rdy_ne_q   <= 1'b0;
              rdy_head_q <= '0;
            end else if (rdy_head_q == s_q) begin
              rdy_head_q <= nxt_rd_q;
            end
          end
        end
        CMD_PLACE: begin
          if (op_q) begin
            free_head_q <= s_q;
            free_ne_q   <= 1'b1;
          end else if (sts_o.place_self) begin
            rdy_head_q <= s_q;
            rdy_ne_q   <= 1'b1;
          end
        end
        CMD_INS_W2: begin
          if (lower_q && at_q == rdy_head_q) begin
            rdy_head_q <= s_q;
          end
        end
        CMD_FIN: begin
          task_q     <= task_d;
          task_vld_q <= task_vld_d;
          out_vld_q  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o     = out_vld_q;
  assign new_slot_o      = new_slot_q;
  assign running_slot_o  = run_slot_q;
  assign running_valid_o = run_vld_q;
  assign status_o        = status_q;

endmodule
`default_nettype wire

/* sv/prqs_checker.sv */
// Port-level assertions of the scheduler and their bind.
`default_nettype none
`include "priority_ready_queue_scheduler_macros.svh"
module prqs_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_i,
  input wire logic                            out_valid_i,
  input wire logic                            out_ready_i,
  input wire logic [prqs_pkg::SLOT_OUT_W-1:0] new_slot_i,
  input wire logic [prqs_pkg::SLOT_OUT_W-1:0] running_slot_i,
  input wire logic                            running_valid_i,
  input wire logic [prqs_pkg::STATUS_W-1:0]   status_i
);
  import prqs_pkg::*;

  `PRQS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(running_slot_i) && $stable(new_slot_i), "result beat dropped or changed while stalled")
  `PRQS_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i, "request taken while previous one in progress")
  `PRQS_ASSERT_WHEN(a_idle_no_task, clk_i, rst_ni, out_valid_i && status_i == STATUS_IDLE, !running_valid_i && running_slot_i == '0, "idle status with a running task")
  `PRQS_ASSERT_WHEN(a_nofree_no_slot, clk_i, rst_ni, out_valid_i && status_i == STATUS_NOFREE, new_slot_i == '0, "slot reported on failed activate")

endmodule

bind priority_ready_queue_scheduler prqs_checker u_prqs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .new_slot_i      (rsp_o.new_slot),
  .running_slot_i  (rsp_o.running_slot),
  .running_valid_i (rsp_o.running_valid),
  .status_i        (rsp_o.status)
);
`default_nettype wire
